// ----- design/vepr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rotation package
// Widths, register indexes, shared types and saturation helpers for the
// pivot rotation unit.
// ----------------------------------------------------------------------------
package vepr_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int ANGLE_W        = 17;
	localparam int CFG_ADDR_W     = 3;
	localparam int NUM_AXES       = 3;
	localparam int AXIS_W         = 2;

	localparam int IW = COORD_WIDTH + 1;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = IW + TW;
	localparam int SW = PW + 1;
	localparam int RW = SW - TRIG_FRAC_BITS;
	localparam int OW = IW + 1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ANGLE_X = 3'd0,
		REG_ANGLE_Y = 3'd1,
		REG_ANGLE_Z = 3'd2,
		REG_PIVOT_X = 3'd3,
		REG_PIVOT_Y = 3'd4,
		REG_PIVOT_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} coef_t;

	typedef struct packed {
		logic                 en;
		logic [AXIS_W-1:0]    axis;
		logic [ANGLE_W-1:0]   angle;
	} angle_wr_t;

	typedef struct packed {
		logic signed [IW-1:0] a;
		logic signed [IW-1:0] b;
		logic signed [IW-1:0] c;
		logic                 last;
	} rot_item_t;

	function automatic logic signed [IW-1:0] sat_rot(input logic signed [RW-1:0] v);
		if (v[RW-1:IW-1] == {(RW-IW+1){v[RW-1]}}) begin
			sat_rot = v[IW-1:0];
		end else begin
			sat_rot = v[RW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_out(input logic signed [OW-1:0] v);
		if (v[OW-1:COORD_WIDTH-1] == {(OW-COORD_WIDTH+1){v[OW-1]}}) begin
			sat_out = v[COORD_WIDTH-1:0];
		end else begin
			sat_out = v[OW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
				: {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	endfunction

endpackage

// ----- design/vepr_trig.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation coefficient unit
// Derives the cosine and sine of each axis angle after it is written, with
// one shared multiplier and a small long divider running a Taylor series.
// ----------------------------------------------------------------------------
module vepr_trig (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  vepr_pkg::angle_wr_t                         wr,
	output logic                                        busy,
	output vepr_pkg::coef_t [vepr_pkg::NUM_AXES-1:0]    coef
);

	localparam int Q         = 30;
	localparam int X_W       = 31;
	localparam int TERM_W    = 32;
	localparam int ACC_W     = 34;
	localparam int U_W       = 18;
	localparam int R_W       = 16;
	localparam int T_W       = 14;
	localparam int MUL_W     = 64;
	localparam int NUM_W     = 36;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = NUM_W / DIV_BITS;
	localparam int CNT_W     = 4;
	localparam int DVS_W     = 8;
	localparam int N_W       = 3;
	localparam int SERIES_TERMS = 7;
	localparam int RND_SH    = Q - vepr_pkg::TRIG_FRAC_BITS;
	localparam int TURN      = 36000;
	localparam int QUART     = 9000;
	localparam int RAD_K     = 191900981;
	localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1) << Q;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REDUCE, ST_SPLIT, ST_MUL_X, ST_ROUND_X, ST_MUL_X2, ST_TAKE_X2,
		ST_MUL_T, ST_DIV_LOAD, ST_DIV, ST_ACC, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

	state_t                                 state_q;
	logic [vepr_pkg::NUM_AXES-1:0]          pend_q;
	logic [vepr_pkg::NUM_AXES-1:0]          pend_n;
	logic [vepr_pkg::ANGLE_W-1:0]           angle_q [vepr_pkg::NUM_AXES];
	logic [vepr_pkg::AXIS_W-1:0]            axis_q;
	logic [vepr_pkg::AXIS_W-1:0]            pick;
	logic signed [vepr_pkg::ANGLE_W-1:0]    ang_q;
	logic [R_W-1:0]                         r_q;
	quad_t                                  quad_q;
	logic [T_W-1:0]                         t_q;
	logic [MUL_W-1:0]                       p_q;
	logic [X_W-1:0]                         x_q;
	logic [TERM_W-1:0]                      x2_q;
	logic [TERM_W-1:0]                      ts_q;
	logic [TERM_W-1:0]                      tc_q;
	logic signed [ACC_W-1:0]                ss_q;
	logic signed [ACC_W-1:0]                cc_q;
	logic [N_W-1:0]                         n_q;
	logic                                   sel_q;
	logic [NUM_W-1:0]                       num_q;
	logic [DVS_W-1:0]                       rem_q;
	logic [CNT_W-1:0]                       cnt_q;
	vepr_pkg::coef_t [vepr_pkg::NUM_AXES-1:0] coef_q;

	logic [U_W-1:0]                         u;
	logic [R_W-1:0]                         red;
	quad_t                                  quad_n;
	logic [T_W-1:0]                         t_n;
	logic [TERM_W-1:0]                      mul_a;
	logic [TERM_W-1:0]                      mul_b;
	logic [DVS_W-1:0]                       divisor;
	logic [DVS_W:0]                         dv_rem;
	logic [NUM_W-1:0]                       dv_num;
	logic signed [ACC_W-1:0]                quo_ext;
	logic signed [vepr_pkg::TW-1:0]         s_v;
	logic signed [vepr_pkg::TW-1:0]         c_v;
	vepr_pkg::coef_t                        fin;

	function automatic logic [DVS_W-1:0] series_div(input logic [N_W-1:0] n, input logic cos_term);
		logic [DVS_W-1:0] d_sin;
		logic [DVS_W-1:0] d_cos;
		case (n)
			3'd1: begin d_sin = 8'd6;   d_cos = 8'd2;   end
			3'd2: begin d_sin = 8'd20;  d_cos = 8'd12;  end
			3'd3: begin d_sin = 8'd42;  d_cos = 8'd30;  end
			3'd4: begin d_sin = 8'd72;  d_cos = 8'd56;  end
			3'd5: begin d_sin = 8'd110; d_cos = 8'd90;  end
			3'd6: begin d_sin = 8'd156; d_cos = 8'd132; end
			default: begin d_sin = 8'd210; d_cos = 8'd182; end
		endcase
		series_div = cos_term ? d_cos : d_sin;
	endfunction

	function automatic logic signed [vepr_pkg::TW-1:0] to_trig(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] pos;
		logic [ACC_W-1:0] rnd;
		pos = v[ACC_W-1] ? '0 : v;
		rnd = (pos + (ACC_W'(1) << (RND_SH - 1))) >> RND_SH;
		if (rnd > (ACC_W'(1) << vepr_pkg::TRIG_FRAC_BITS)) begin
			rnd = ACC_W'(1) << vepr_pkg::TRIG_FRAC_BITS;
		end
		to_trig = vepr_pkg::TW'(rnd);
	endfunction

	always_comb begin
		if (pend_q[0]) begin
			pick = 2'd0;
		end else if (pend_q[1]) begin
			pick = 2'd1;
		end else begin
			pick = 2'd2;
		end
		pend_n = pend_q;
		if (state_q == ST_IDLE && |pend_q) begin
			pend_n[pick] = 1'b0;
		end
		if (wr.en) begin
			pend_n[wr.axis] = 1'b1;
		end
	end

	// Angle folded onto one full turn, then split into quadrant and offset.
	always_comb begin
		u = U_W'(19'(ang_q) + 19'sd72000);
		if (u >= U_W'(3 * TURN)) begin
			red = R_W'(u - U_W'(3 * TURN));
		end else if (u >= U_W'(2 * TURN)) begin
			red = R_W'(u - U_W'(2 * TURN));
		end else if (u >= U_W'(TURN)) begin
			red = R_W'(u - U_W'(TURN));
		end else begin
			red = R_W'(u);
		end
		if (r_q >= R_W'(3 * QUART)) begin
			quad_n = QUAD_3;
			t_n = T_W'(r_q - R_W'(3 * QUART));
		end else if (r_q >= R_W'(2 * QUART)) begin
			quad_n = QUAD_2;
			t_n = T_W'(r_q - R_W'(2 * QUART));
		end else if (r_q >= R_W'(QUART)) begin
			quad_n = QUAD_1;
			t_n = T_W'(r_q - R_W'(QUART));
		end else begin
			quad_n = QUAD_0;
			t_n = T_W'(r_q);
		end
	end

	always_comb begin
		case (state_q)
			ST_MUL_X: begin
				mul_a = TERM_W'(t_q);
				mul_b = TERM_W'(RAD_K);
			end
			ST_MUL_X2: begin
				mul_a = TERM_W'(x_q);
				mul_b = TERM_W'(x_q);
			end
			default: begin
				mul_a = sel_q ? tc_q : ts_q;
				mul_b = x2_q;
			end
		endcase
	end

	always_comb begin
		divisor = series_div(n_q, sel_q);
		dv_rem = {1'b0, rem_q};
		dv_num = num_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			dv_rem = {dv_rem[DVS_W-1:0], dv_num[NUM_W-1]};
			dv_num = {dv_num[NUM_W-2:0], 1'b0};
			if (dv_rem >= {1'b0, divisor}) begin
				dv_rem = dv_rem - {1'b0, divisor};
				dv_num[0] = 1'b1;
			end
		end
		quo_ext = ACC_W'(num_q[TERM_W-1:0]);
	end

	always_comb begin
		s_v = to_trig(ss_q);
		c_v = to_trig(cc_q);
		case (quad_q)
			QUAD_0: begin
				fin.c = c_v;
				fin.s = s_v;
			end
			QUAD_1: begin
				fin.c = -s_v;
				fin.s = c_v;
			end
			QUAD_2: begin
				fin.c = -c_v;
				fin.s = -s_v;
			end
			default: begin
				fin.c = s_v;
				fin.s = -c_v;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= '0;
			for (int k = 0; k < vepr_pkg::NUM_AXES; k++) begin
				coef_q[k].c <= vepr_pkg::TW'(1) << vepr_pkg::TRIG_FRAC_BITS;
				coef_q[k].s <= '0;
			end
		end else begin
			pend_q <= pend_n;
			case (state_q)
				ST_IDLE: begin
					if (|pend_q) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE:   state_q <= ST_SPLIT;
				ST_SPLIT:    state_q <= ST_MUL_X;
				ST_MUL_X:    state_q <= ST_ROUND_X;
				ST_ROUND_X:  state_q <= ST_MUL_X2;
				ST_MUL_X2:   state_q <= ST_TAKE_X2;
				ST_TAKE_X2:  state_q <= ST_MUL_T;
				ST_MUL_T:    state_q <= ST_DIV_LOAD;
				ST_DIV_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (sel_q && n_q == N_W'(SERIES_TERMS)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_MUL_T;
					end
				end
				ST_FINISH: begin
					coef_q[axis_q] <= fin;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			angle_q[wr.axis] <= wr.angle;
		end
		case (state_q)
			ST_IDLE: begin
				axis_q <= pick;
				ang_q <= angle_q[pick];
			end
			ST_REDUCE: r_q <= red;
			ST_SPLIT: begin
				quad_q <= quad_n;
				t_q <= t_n;
			end
			ST_MUL_X, ST_MUL_X2, ST_MUL_T: begin
				p_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
			end
			ST_ROUND_X: x_q <= X_W'((p_q + MUL_W'(512)) >> 10);
			ST_TAKE_X2: begin
				x2_q <= TERM_W'(p_q >> Q);
				ts_q <= TERM_W'(x_q);
				tc_q <= ONE_Q30;
				ss_q <= ACC_W'(x_q);
				cc_q <= ACC_W'(ONE_Q30);
				n_q <= N_W'(1);
				sel_q <= 1'b0;
			end
			ST_DIV_LOAD: begin
				num_q <= NUM_W'(p_q >> Q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				num_q <= dv_num;
				rem_q <= dv_rem[DVS_W-1:0];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_ACC: begin
				if (!sel_q) begin
					ts_q <= num_q[TERM_W-1:0];
					ss_q <= n_q[0] ? ss_q - quo_ext : ss_q + quo_ext;
				end else begin
					tc_q <= num_q[TERM_W-1:0];
					cc_q <= n_q[0] ? cc_q - quo_ext : cc_q + quo_ext;
					n_q <= n_q + N_W'(1);
				end
				sel_q <= !sel_q;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE) || (|pend_q);
	assign coef = coef_q;

endmodule

// ----- design/vepr_rot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane rotation stage
// Two pipeline stages: four products, then two rounded and saturated sums
// giving a' = a*cos - b*sin and b' = a*sin + b*cos.
// ----------------------------------------------------------------------------
module vepr_rot (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  vepr_pkg::rot_item_t    up_item,
	input  vepr_pkg::coef_t        coef,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output vepr_pkg::rot_item_t    dn_item
);

	localparam logic signed [vepr_pkg::SW-1:0] ROUND_HALF =
		vepr_pkg::SW'(1) << (vepr_pkg::TRIG_FRAC_BITS - 1);

	logic                               v_s1;
	logic                               v_s2;
	logic                               rdy_s1;
	logic                               rdy_s2;
	logic signed [vepr_pkg::PW-1:0]     pac_s1;
	logic signed [vepr_pkg::PW-1:0]     pbs_s1;
	logic signed [vepr_pkg::PW-1:0]     pas_s1;
	logic signed [vepr_pkg::PW-1:0]     pbc_s1;
	logic signed [vepr_pkg::IW-1:0]     c_s1;
	logic                               last_s1;
	vepr_pkg::rot_item_t                item_s2;
	logic signed [vepr_pkg::SW-1:0]     sum_a;
	logic signed [vepr_pkg::SW-1:0]     sum_b;

	assign rdy_s2 = !v_s2 || dn_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign sum_a = vepr_pkg::SW'(pac_s1) - vepr_pkg::SW'(pbs_s1) + ROUND_HALF;
	assign sum_b = vepr_pkg::SW'(pas_s1) + vepr_pkg::SW'(pbc_s1) + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			pac_s1 <= vepr_pkg::PW'(up_item.a) * vepr_pkg::PW'(coef.c);
			pbs_s1 <= vepr_pkg::PW'(up_item.b) * vepr_pkg::PW'(coef.s);
			pas_s1 <= vepr_pkg::PW'(up_item.a) * vepr_pkg::PW'(coef.s);
			pbc_s1 <= vepr_pkg::PW'(up_item.b) * vepr_pkg::PW'(coef.c);
			c_s1 <= up_item.c;
			last_s1 <= up_item.last;
		end
		if (rdy_s2 && v_s1) begin
			item_s2.a <= vepr_pkg::sat_rot(sum_a[vepr_pkg::SW-1:vepr_pkg::TRIG_FRAC_BITS]);
			item_s2.b <= vepr_pkg::sat_rot(sum_b[vepr_pkg::SW-1:vepr_pkg::TRIG_FRAC_BITS]);
			item_s2.c <= c_s1;
			item_s2.last <= last_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_item = item_s2;

endmodule

// ----- design/vertex_euler_rotate_about_pivot_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rotation about a pivot
// Subtracts the pivot, rotates about X, Y and Z in turn, adds the pivot back.
//
//   channel   signals                                   direction
//   config    cfg_wr_en, cfg_addr, cfg_wdata            in
//   vertex    in_valid, in_stall, in_x/y/z, in_last     in
//   result    out_valid, out_stall, out_x/y/z, out_last out
//
// One vertex per cycle while in_stall is low, through eight register stages: the
// input stage, two in each of the X, Y and Z rotations, and the output stage.
// After each angle write the coefficient unit works through its shared multiplier
// and four-bit-per-cycle divider; in_stall is high while it is busy.
// Reset sets cosines to one, sines and pivot to zero; there is no clearing pass.
// A result stall holds, in the same cycle, each occupied stage with no empty
// stage ahead of it, while the others move up; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vertex_euler_rotate_about_pivot_unit (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_wr_en,
	input  logic [vepr_pkg::CFG_ADDR_W-1:0]             cfg_addr,
	input  logic [vepr_pkg::COORD_WIDTH-1:0]            cfg_wdata,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic signed [vepr_pkg::COORD_WIDTH-1:0]     in_x,
	input  logic signed [vepr_pkg::COORD_WIDTH-1:0]     in_y,
	input  logic signed [vepr_pkg::COORD_WIDTH-1:0]     in_z,
	input  logic                                        in_last,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic signed [vepr_pkg::COORD_WIDTH-1:0]     out_x,
	output logic signed [vepr_pkg::COORD_WIDTH-1:0]     out_y,
	output logic signed [vepr_pkg::COORD_WIDTH-1:0]     out_z,
	output logic                                        out_last
);

	logic signed [vepr_pkg::COORD_WIDTH-1:0]            pivot_q [vepr_pkg::NUM_AXES];
	vepr_pkg::angle_wr_t                                ang_wr;
	vepr_pkg::coef_t [vepr_pkg::NUM_AXES-1:0]           coef;
	logic                                               trig_busy;

	logic                                               v_s1;
	logic                                               rdy_s1;
	logic                                               accept;
	logic signed [vepr_pkg::IW-1:0]                     x_s1;
	logic signed [vepr_pkg::IW-1:0]                     y_s1;
	logic signed [vepr_pkg::IW-1:0]                     z_s1;
	logic                                               last_s1;

	vepr_pkg::rot_item_t                                rx_in;
	vepr_pkg::rot_item_t                                rx_out;
	vepr_pkg::rot_item_t                                ry_in;
	vepr_pkg::rot_item_t                                ry_out;
	vepr_pkg::rot_item_t                                rz_in;
	vepr_pkg::rot_item_t                                rz_out;
	logic                                               rx_ready;
	logic                                               rx_valid;
	logic                                               ry_ready;
	logic                                               ry_valid;
	logic                                               rz_ready;
	logic                                               rz_valid;

	logic                                               v_s8;
	logic                                               rdy_s8;
	logic signed [vepr_pkg::COORD_WIDTH-1:0]            x_s8;
	logic signed [vepr_pkg::COORD_WIDTH-1:0]            y_s8;
	logic signed [vepr_pkg::COORD_WIDTH-1:0]            z_s8;
	logic                                               last_s8;

	always_comb begin
		ang_wr.en = cfg_wr_en && (cfg_addr == vepr_pkg::REG_ANGLE_X
			|| cfg_addr == vepr_pkg::REG_ANGLE_Y || cfg_addr == vepr_pkg::REG_ANGLE_Z);
		ang_wr.axis = cfg_addr[vepr_pkg::AXIS_W-1:0];
		ang_wr.angle = cfg_wdata[vepr_pkg::ANGLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < vepr_pkg::NUM_AXES; k++) begin
				pivot_q[k] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				vepr_pkg::REG_PIVOT_X: pivot_q[0] <= cfg_wdata;
				vepr_pkg::REG_PIVOT_Y: pivot_q[1] <= cfg_wdata;
				vepr_pkg::REG_PIVOT_Z: pivot_q[2] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	vepr_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ang_wr),
		.busy   (trig_busy),
		.coef   (coef)
	);

	assign rdy_s1 = !v_s1 || rx_ready;
	assign in_stall = !rdy_s1 || trig_busy;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept;
			end
			if (rdy_s8) begin
				v_s8 <= rz_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= vepr_pkg::IW'(in_x) - vepr_pkg::IW'(pivot_q[0]);
			y_s1 <= vepr_pkg::IW'(in_y) - vepr_pkg::IW'(pivot_q[1]);
			z_s1 <= vepr_pkg::IW'(in_z) - vepr_pkg::IW'(pivot_q[2]);
			last_s1 <= in_last;
		end
		if (rdy_s8 && rz_valid) begin
			x_s8 <= vepr_pkg::sat_out(vepr_pkg::OW'(rz_out.a) + vepr_pkg::OW'(pivot_q[0]));
			y_s8 <= vepr_pkg::sat_out(vepr_pkg::OW'(rz_out.b) + vepr_pkg::OW'(pivot_q[1]));
			z_s8 <= vepr_pkg::sat_out(vepr_pkg::OW'(rz_out.c) + vepr_pkg::OW'(pivot_q[2]));
			last_s8 <= rz_out.last;
		end
	end

	// Each stage rotates its (a, b) pair; c rides along as the third axis.
	always_comb begin
		rx_in.a = y_s1;
		rx_in.b = z_s1;
		rx_in.c = x_s1;
		rx_in.last = last_s1;
		ry_in.a = rx_out.b;
		ry_in.b = rx_out.c;
		ry_in.c = rx_out.a;
		ry_in.last = rx_out.last;
		rz_in.a = ry_out.b;
		rz_in.b = ry_out.c;
		rz_in.c = ry_out.a;
		rz_in.last = ry_out.last;
	end

	vepr_rot u_rot_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_ready (rx_ready),
		.up_item  (rx_in),
		.coef     (coef[0]),
		.dn_valid (rx_valid),
		.dn_ready (ry_ready),
		.dn_item  (rx_out)
	);

	vepr_rot u_rot_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (rx_valid),
		.up_ready (ry_ready),
		.up_item  (ry_in),
		.coef     (coef[1]),
		.dn_valid (ry_valid),
		.dn_ready (rz_ready),
		.dn_item  (ry_out)
	);

	vepr_rot u_rot_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ry_valid),
		.up_ready (rz_ready),
		.up_item  (rz_in),
		.coef     (coef[2]),
		.dn_valid (rz_valid),
		.dn_ready (rdy_s8),
		.dn_item  (rz_out)
	);

	assign rdy_s8 = !v_s8 || !out_stall;

	assign out_valid = v_s8;
	assign out_x = x_s8;
	assign out_y = y_s8;
	assign out_z = z_s8;
	assign out_last = last_s8;

endmodule
